@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/jlvb_pkg.sv @@
// ----------------------------------------------------------------------------
// jlvb_pkg
// Types, widths and the tanh table builder for the velocity bound shaper.
// ----------------------------------------------------------------------------
package jlvb_pkg;

    localparam int PW = 26;                  // scaled position width (x80)
    localparam int GW = 18;                  // guard width, positive in a band
    localparam int VW = 16;                  // velocity width
    localparam int SW = 17;                  // scale width, signed, 0..32768
    localparam int HW = 15;                  // tanh table entry width
    localparam int TANH_DEPTH_DEFAULT = 256;
    localparam int TANH_MAX_DEPTH = 4096;
    localparam logic signed [SW-1:0] SCALE_ONE = 17'sd32768;
    localparam logic signed [SW-1:0] SCALE_HALF = 17'sd16384;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef enum logic [2:0] {
        REG_MID     = 3'd0,
        REG_LO_ZERO = 3'd1,
        REG_LO_BAND = 3'd2,
        REG_HI_ZERO = 3'd3,
        REG_HI_BAND = 3'd4
    } region_t;

    typedef struct packed {
        logic signed [VW-1:0] vel_low;
        logic signed [VW-1:0] vel_high;
        region_t              region;
        logic                 pos;
    } side_t;

    // shift-subtract divide, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // entry i = round(16384 * tanh(5*i/depth)), packed HW bits per entry
    function automatic logic [TANH_MAX_DEPTH*HW-1:0] tanh_build(input int depth);
        logic [63:0]        z;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        step;
        logic [63:0]        e;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [TANH_MAX_DEPTH*HW-1:0] t;
        z = udiv64(64'd10 << 30, 64'(depth));
        term = ONE_Q30;
        sum = signed'(ONE_Q30);
        e = ONE_Q30;
        t = '0;
        for (int k = 1; k <= 16; k++)
        begin
            term = udiv64((term * z) >> 30, 64'(k));
            if (k % 2 == 1)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > signed'(ONE_Q30))
            sum = signed'(ONE_Q30);
        step = unsigned'(sum);
        for (int i = 0; i < TANH_MAX_DEPTH; i++)
        begin
            if (i < depth)
            begin
                num = 64'd32768 * (ONE_Q30 - e) + (ONE_Q30 + e);
                den = 64'd2 * (ONE_Q30 + e);
                t[i*HW +: HW] = HW'(udiv64(num, den));
                e = (e * step + (64'd1 << 29)) >> 30;
            end
        end
        return t;
    endfunction

endpackage

@@ rtl/core/joint_limit_velocity_bounds_top.sv @@
// ----------------------------------------------------------------------------
// joint_limit_velocity_bounds_top
// Joint-limit velocity bound shaper, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | joint_angle joint_min joint_max vel_low vel_high
//  out     | out_valid / out_stall| bound_low bound_high
//
//  One word enters per cycle unless in_stall is high; the pipeline depth is
//  set by the one-bit-per-stage guard divider.
//  Each stage holds its word while the next stage is full and stalled; bubbles
//  close up, so input is taken while a result waits at the output.
//  Reset clears the stage valid bits only; the tanh table is constant logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module joint_limit_velocity_bounds_top #(
    parameter int TANH_TABLE_DEPTH = jlvb_pkg::TANH_DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [jlvb_pkg::VW-1:0] joint_angle,
    input  logic signed [jlvb_pkg::VW-1:0] joint_min,
    input  logic signed [jlvb_pkg::VW-1:0] joint_max,
    input  logic signed [jlvb_pkg::VW-1:0] vel_low,
    input  logic signed [jlvb_pkg::VW-1:0] vel_high,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [jlvb_pkg::VW-1:0] bound_low,
    output logic signed [jlvb_pkg::VW-1:0] bound_high
);
    localparam int QW = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int XW = jlvb_pkg::PW + QW + 2;
    localparam int S  = QW + 4;

    logic [S-1:0] valid_reg, valid_next, free;

    logic [XW-1:0]           rem_s   [QW+1];
    logic [QW-1:0]           quo_s   [QW+1];
    logic [jlvb_pkg::GW-1:0] guard_s [QW+1];
    jlvb_pkg::side_t         side_s  [QW+1];

    // a stage loads when empty or when its word moves on
    always_comb
    begin
        free[S-1] = !valid_reg[S-1] || !out_stall;
        for (int i = S - 2; i >= 0; i--)
            free[i] = !valid_reg[i] || free[i+1];
        for (int i = 0; i < S; i++)
        begin
            if (!free[i])
                valid_next[i] = valid_reg[i];
            else if (i == 0)
                valid_next[i] = in_valid;
            else
                valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_stall  = !free[0];
    assign out_valid = valid_reg[S-1];
    assign quo_s[0]  = '0;

    jlvb_front #(.TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)) u_front (
        .clk         (clk),
        .en1         (free[0]),
        .en2         (free[1]),
        .joint_angle (joint_angle),
        .joint_min   (joint_min),
        .joint_max   (joint_max),
        .vel_low     (vel_low),
        .vel_high    (vel_high),
        .side        (side_s[0]),
        .rem         (rem_s[0]),
        .guard       (guard_s[0])
    );

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        jlvb_div_step #(.TANH_TABLE_DEPTH(TANH_TABLE_DEPTH), .K(QW - 1 - j)) u_step (
            .clk       (clk),
            .en        (free[2+j]),
            .rem_in    (rem_s[j]),
            .quo_in    (quo_s[j]),
            .guard_in  (guard_s[j]),
            .side_in   (side_s[j]),
            .rem_out   (rem_s[j+1]),
            .quo_out   (quo_s[j+1]),
            .guard_out (guard_s[j+1]),
            .side_out  (side_s[j+1])
        );
    end

    jlvb_back #(.TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)) u_back (
        .clk        (clk),
        .en1        (free[S-2]),
        .en2        (free[S-1]),
        .quo_in     (quo_s[QW]),
        .side_in    (side_s[QW]),
        .bound_low  (bound_low),
        .bound_high (bound_high)
    );

    `CHK_NOW(a_stall_full, in_stall, &valid_reg, "input stalled with a free stage")
    `CHK_NEXT(a_enter, in_valid && !in_stall, valid_reg[0], "accepted word not in stage 0")
    `CHK_NEXT(a_drain, out_valid && !out_stall && !valid_reg[S-2], !out_valid,
        "output word repeated")
endmodule

@@ rtl/core/jlvb_front.sv @@
// ----------------------------------------------------------------------------
// jlvb_front
// Two stages: scale positions by 80, then classify the angle and form the
// divider numerator.
// ----------------------------------------------------------------------------
module jlvb_front #(
    parameter int TANH_TABLE_DEPTH = jlvb_pkg::TANH_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              en1,
    input  logic                              en2,
    input  logic signed [jlvb_pkg::VW-1:0]    joint_angle,
    input  logic signed [jlvb_pkg::VW-1:0]    joint_min,
    input  logic signed [jlvb_pkg::VW-1:0]    joint_max,
    input  logic signed [jlvb_pkg::VW-1:0]    vel_low,
    input  logic signed [jlvb_pkg::VW-1:0]    vel_high,
    output jlvb_pkg::side_t                   side,
    output logic [jlvb_pkg::PW+$clog2(TANH_TABLE_DEPTH+1)+1:0] rem,
    output logic [jlvb_pkg::GW-1:0]           guard
);
    localparam int PW = jlvb_pkg::PW;
    localparam int QW = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int XW = PW + QW + 2;

    logic signed [PW-1:0] q80_reg, q80_next;
    logic signed [PW-1:0] mn80_reg, mn80_next;
    logic signed [PW-1:0] mx80_reg, mx80_next;
    logic signed [PW-1:0] diff_reg, diff_next;
    logic signed [jlvb_pkg::VW-1:0] vl_reg, vh_reg;

    jlvb_pkg::side_t side_reg, side_next;
    logic [XW-1:0] rem_reg, rem_next;
    logic [jlvb_pkg::GW-1:0] guard_reg, guard_next;

    logic signed [PW-1:0] g, min_ext, min_int, min_cog, max_ext, max_int, max_cog, d;
    logic [PW-1:0] mag;

    always_comb
    begin
        q80_next  = (PW'(joint_angle) <<< 6) + (PW'(joint_angle) <<< 4);
        mn80_next = (PW'(joint_min) <<< 6) + (PW'(joint_min) <<< 4);
        mx80_next = (PW'(joint_max) <<< 6) + (PW'(joint_max) <<< 4);
        diff_next = PW'(joint_max) - PW'(joint_min);
    end

    always_comb
    begin
        g       = diff_reg <<< 1;
        min_ext = mn80_reg + g;
        min_int = mn80_reg + (g <<< 1);
        min_cog = mn80_reg + g + diff_reg;
        max_ext = mx80_reg - g;
        max_int = mx80_reg - (g <<< 1);
        max_cog = mx80_reg - g - diff_reg;
        side_next.vel_low  = vl_reg;
        side_next.vel_high = vh_reg;
        side_next.pos      = 1'b0;
        d = '0;
        if (q80_reg >= min_int && q80_reg <= max_int)
            side_next.region = jlvb_pkg::REG_MID;
        else if (q80_reg < min_int)
        begin
            if (q80_reg <= min_ext)
                side_next.region = jlvb_pkg::REG_LO_ZERO;
            else
            begin
                side_next.region = jlvb_pkg::REG_LO_BAND;
                d = q80_reg - min_cog;
                side_next.pos = (d > 0);
            end
        end
        else
        begin
            if (q80_reg >= max_ext)
                side_next.region = jlvb_pkg::REG_HI_ZERO;
            else
            begin
                side_next.region = jlvb_pkg::REG_HI_BAND;
                d = q80_reg - max_cog;
                side_next.pos = (d < 0);
            end
        end
        // a band is only reachable with a positive guard
        mag = d[PW-1] ? PW'(-d) : PW'(d);
        rem_next = XW'(mag) * XW'(2 * TANH_TABLE_DEPTH);
        guard_next = g[jlvb_pkg::GW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            q80_reg  <= q80_next;
            mn80_reg <= mn80_next;
            mx80_reg <= mx80_next;
            diff_reg <= diff_next;
            vl_reg   <= vel_low;
            vh_reg   <= vel_high;
        end
        if (en2)
        begin
            side_reg  <= side_next;
            rem_reg   <= rem_next;
            guard_reg <= guard_next;
        end
    end

    assign side  = side_reg;
    assign rem   = rem_reg;
    assign guard = guard_reg;
endmodule

@@ rtl/core/jlvb_div_step.sv @@
// ----------------------------------------------------------------------------
// jlvb_div_step
// One restoring divider stage: resolves quotient bit K.
// ----------------------------------------------------------------------------
module jlvb_div_step #(
    parameter int TANH_TABLE_DEPTH = jlvb_pkg::TANH_DEPTH_DEFAULT,
    parameter int K = 0
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [jlvb_pkg::PW+$clog2(TANH_TABLE_DEPTH+1)+1:0] rem_in,
    input  logic [$clog2(TANH_TABLE_DEPTH+1)-1:0] quo_in,
    input  logic [jlvb_pkg::GW-1:0] guard_in,
    input  jlvb_pkg::side_t         side_in,
    output logic [jlvb_pkg::PW+$clog2(TANH_TABLE_DEPTH+1)+1:0] rem_out,
    output logic [$clog2(TANH_TABLE_DEPTH+1)-1:0] quo_out,
    output logic [jlvb_pkg::GW-1:0] guard_out,
    output jlvb_pkg::side_t         side_out
);
    localparam int QW = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int XW = jlvb_pkg::PW + QW + 2;

    logic [XW-1:0] rem_reg, rem_next, shifted;
    logic [QW-1:0] quo_reg, quo_next;
    logic [jlvb_pkg::GW-1:0] guard_reg;
    jlvb_pkg::side_t side_reg;

    always_comb
    begin
        shifted  = XW'(guard_in) << K;
        rem_next = rem_in;
        quo_next = quo_in;
        if (rem_in >= shifted)
        begin
            rem_next    = rem_in - shifted;
            quo_next[K] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            guard_reg <= guard_in;
            side_reg  <= side_in;
        end
    end

    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign guard_out = guard_reg;
    assign side_out  = side_reg;
endmodule

@@ rtl/core/jlvb_back.sv @@
// ----------------------------------------------------------------------------
// jlvb_back
// Two stages: tanh lookup and scale select, then velocity multiply, round
// and saturate.
// ----------------------------------------------------------------------------
module jlvb_back #(
    parameter int TANH_TABLE_DEPTH = jlvb_pkg::TANH_DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           en1,
    input  logic                           en2,
    input  logic [$clog2(TANH_TABLE_DEPTH+1)-1:0] quo_in,
    input  jlvb_pkg::side_t                side_in,
    output logic signed [jlvb_pkg::VW-1:0] bound_low,
    output logic signed [jlvb_pkg::VW-1:0] bound_high
);
    localparam int QW = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int IW = $clog2(TANH_TABLE_DEPTH);
    localparam int HW = jlvb_pkg::HW;
    localparam int SW = jlvb_pkg::SW;
    localparam int VW = jlvb_pkg::VW;
    localparam int MW = VW + SW + 1;
    localparam logic [jlvb_pkg::TANH_MAX_DEPTH*HW-1:0] TANH_TBL =
        jlvb_pkg::tanh_build(TANH_TABLE_DEPTH);
    localparam logic [QW-1:0] IDX_LAST = QW'(TANH_TABLE_DEPTH - 1);

    logic [IW-1:0] idx;
    logic signed [SW-1:0] h, s_band;
    logic signed [SW-1:0] slo_reg, slo_next, shi_reg, shi_next;
    logic signed [VW-1:0] vl_reg, vh_reg;
    logic signed [VW-1:0] blo_reg, blo_next, bhi_reg, bhi_next;

    function automatic logic signed [VW-1:0] apply(input logic signed [VW-1:0] v,
                                                    input logic signed [SW-1:0] s);
        logic signed [MW-1:0] p;
        logic signed [MW-1:0] r;
        p = MW'(v) * MW'(s) + MW'(jlvb_pkg::SCALE_HALF);
        r = p >>> 15;
        if (r > MW'(32767))
            return 16'sh7fff;
        else if (r < -MW'(32768))
            return -16'sh8000;
        else
            return r[VW-1:0];
    endfunction

    always_comb
    begin
        // clamp to the last entry
        idx = (quo_in > IDX_LAST) ? IDX_LAST[IW-1:0] : quo_in[IW-1:0];
        h = SW'(TANH_TBL[idx*HW +: HW]);
        s_band = side_in.pos ? jlvb_pkg::SCALE_HALF + h : jlvb_pkg::SCALE_HALF - h;
        slo_next = jlvb_pkg::SCALE_ONE;
        shi_next = jlvb_pkg::SCALE_ONE;
        case (side_in.region)
            jlvb_pkg::REG_MID: ;
            jlvb_pkg::REG_LO_ZERO: slo_next = '0;
            jlvb_pkg::REG_LO_BAND: slo_next = s_band;
            jlvb_pkg::REG_HI_ZERO: shi_next = '0;
            jlvb_pkg::REG_HI_BAND: shi_next = s_band;
            default: ;
        endcase
        blo_next = apply(vl_reg, slo_reg);
        bhi_next = apply(vh_reg, shi_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            slo_reg <= slo_next;
            shi_reg <= shi_next;
            vl_reg  <= side_in.vel_low;
            vh_reg  <= side_in.vel_high;
        end
        if (en2)
        begin
            blo_reg <= blo_next;
            bhi_reg <= bhi_next;
        end
    end

    assign bound_low  = blo_reg;
    assign bound_high = bhi_reg;
endmodule
